// File: src/seven_point_stencil_3d_core_defines.svh
// Assertion macros shared by the stencil core checker.
`ifndef SEVEN_POINT_STENCIL_3D_CORE_DEFINES_SVH
`define SEVEN_POINT_STENCIL_3D_CORE_DEFINES_SVH

// Same-cycle implication, off during reset.
`define SPS3D_CHECK_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off during reset.
`define SPS3D_CHECK_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Condition that must hold in the cycle after reset is sampled low.
`define SPS3D_CHECK_RESET(lbl, clk, rst_n, cons, msg) \
    lbl: assert property (@(posedge clk) (!rst_n) |=> (cons)) else $error(msg);

`endif

// File: src/sps3d_pkg.sv
// Types and constants shared by the stencil core modules.
package sps3d_pkg;

    localparam int SAMPLE_W   = 32;
    localparam int WEIGHT_W   = 18;
    localparam int FRAC_BITS  = 18;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;
    localparam int SIZE_X_W   = 11;
    localparam int SIZE_X_MAX = 1024;
    localparam int SIZE_RST   = 64;
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam logic [WEIGHT_W-1:0] CENTRE_W_RST = 18'd131072;
    localparam logic [WEIGHT_W-1:0] FACE_W_RST   = 18'd21845;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SIZE_X   = 3'd0,
        CFG_SIZE_Y   = 3'd1,
        CFG_SIZE_Z   = 3'd2,
        CFG_CENTRE_W = 3'd3,
        CFG_FACE_W   = 3'd4
    } t_cfg_reg;

    // Operands of one interior point, handed from the delay chain to the math
    typedef struct packed {
        logic                       valid;
        logic                       last;
        logic signed [SAMPLE_W-1:0] s;   // +x face (the sample itself)
        logic signed [SAMPLE_W-1:0] f;   // -x face
        logic signed [SAMPLE_W-1:0] e;   // -y face
        logic signed [SAMPLE_W-1:0] a;   // +y face
        logic signed [SAMPLE_W-1:0] b;   // +z face
        logic signed [SAMPLE_W-1:0] d;   // -z face
        logic signed [SAMPLE_W-1:0] c;   // centre
    } t_operands;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] value;
        logic                       last;
        logic                       clipped;
    } t_result;

endpackage

// File: src/sps3d_arith.sv
// Weighted sum, rounding and saturation pipeline of the stencil core.
module sps3d_arith (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  sps3d_pkg::t_operands             i_op,
    input  logic [sps3d_pkg::WEIGHT_W-1:0]   i_centre_w,
    input  logic [sps3d_pkg::WEIGHT_W-1:0]   i_face_w,
    output logic                             o_push,
    output sps3d_pkg::t_result               o_res,
    output logic [1:0]                       o_pending
);
    import sps3d_pkg::*;

    localparam int P_W   = SAMPLE_W + 2;              // sum of three samples
    localparam int F_W   = SAMPLE_W + 3;              // sum of six samples
    localparam int PF_W  = F_W + WEIGHT_W + 1;
    localparam int PC_W  = SAMPLE_W + WEIGHT_W + 1;
    localparam int ACC_W = PF_W + 1;

    localparam logic signed [ACC_W-1:0] RND    = ACC_W'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(2147483647);
    localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

    logic r_v1, r_v2, r_v3;
    logic r_l1, r_l2, r_l3;
    logic signed [P_W-1:0]      r_p0, r_p1;
    logic signed [SAMPLE_W-1:0] r_c1, r_c2;
    logic signed [F_W-1:0]      r_faces;
    logic signed [PF_W-1:0]     r_pf;
    logic signed [PC_W-1:0]     r_pc;

    logic signed [ACC_W-1:0]    acc;
    logic signed [ACC_W-1:0]    shifted;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_op.valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        // split the six-way face sum over two stages
        r_p0    <= P_W'(i_op.s) + P_W'(i_op.f) + P_W'(i_op.e);
        r_p1    <= P_W'(i_op.a) + P_W'(i_op.b) + P_W'(i_op.d);
        r_c1    <= i_op.c;
        r_l1    <= i_op.last;

        r_faces <= F_W'(r_p0) + F_W'(r_p1);
        r_c2    <= r_c1;
        r_l2    <= r_l1;

        r_pf    <= PF_W'(r_faces) * PF_W'($signed({1'b0, i_face_w}));
        r_pc    <= PC_W'(r_c2) * PC_W'($signed({1'b0, i_centre_w}));
        r_l3    <= r_l2;
    end

    always_comb begin
        acc     = ACC_W'(r_pf) + ACC_W'(r_pc) + RND;
        shifted = acc >>> FRAC_BITS;
        o_res.last = r_l3;
        if (shifted > SAT_HI) begin
            o_res.value   = SAT_HI[SAMPLE_W-1:0];
            o_res.clipped = 1'b1;
        end else if (shifted < SAT_LO) begin
            o_res.value   = SAT_LO[SAMPLE_W-1:0];
            o_res.clipped = 1'b1;
        end else begin
            o_res.value   = shifted[SAMPLE_W-1:0];
            o_res.clipped = 1'b0;
        end
    end

    assign o_push    = r_v3;
    assign o_pending = {1'b0, r_v1} + {1'b0, r_v2} + {1'b0, r_v3};

endmodule

// File: src/sps3d_out_fifo.sv
// Small result queue that decouples the stencil pipeline from the receiver.
module sps3d_out_fifo (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_push,
    input  sps3d_pkg::t_result                  i_data,
    output logic                                o_valid,
    input  logic                                i_ready,
    output sps3d_pkg::t_result                  o_data,
    output logic [sps3d_pkg::FIFO_CNT_W-1:0]    o_count
);
    import sps3d_pkg::*;

    localparam int PTR_W = $clog2(FIFO_DEPTH);

    t_result                r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]       r_wr, r_rd;
    logic [FIFO_CNT_W-1:0]  r_cnt;
    logic                   pop;

    assign pop     = o_valid && i_ready;
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign o_count = r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push, pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// File: src/seven_point_stencil_3d_core.sv
// Top level of the streaming seven-point 3D stencil core.
//
// Usage: the halo-padded grid streams in on i_sample (valid/ready), x slowest,
// z fastest, one request per cycle while o_ready is high. Each interior point
// produces one request on o_value/o_last/o_clipped (valid/ready) once its +x
// neighbour arrives; halo samples produce nothing. o_last marks the last one.
// Config port (i_cfg_valid/o_cfg_ready, always ready) writes sizes and weights;
// a size write restarts the frame at padded point (0,0,0).
// Throughput: one sample per cycle while the receiver keeps up. A result
// reaches o_valid after the sample that completes it passes two delay-memory
// read stages, three arithmetic stages and the queue write.
// Neighbours come from two dual-port memories: one holds two plane-sized
// delay segments side by side, the other two row-sized segments; both are
// read once and written once per sample. Segment lengths are at least two,
// so no read ever hits an entry still waiting to be written.
// When the receiver stalls, results collect in an 8-entry queue; o_ready drops
// once queue entries plus results in flight reach the queue depth.
// Reset (synchronous, active low) empties pipeline and queue, returns sizes
// to 64 and weights to 0.5 and 1/12. Delay memories are not cleared.
module seven_point_stencil_3d_core #(
    parameter int MAX_Y = 64,
    parameter int MAX_Z = 64
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // sample stream
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic signed [sps3d_pkg::SAMPLE_W-1:0] i_sample,
    // result stream
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic signed [sps3d_pkg::SAMPLE_W-1:0] o_value,
    output logic                                  o_last,
    output logic                                  o_clipped,
    // register writes
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [sps3d_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [sps3d_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import sps3d_pkg::*;

    localparam int XW     = SIZE_X_W;
    localparam int YW     = $clog2(MAX_Y + 3);
    localparam int ZW     = $clog2(MAX_Z + 3);
    localparam int DEPTH1 = (MAX_Y + 1) * (MAX_Z + 2);   // plane minus one row
    localparam int DEPTH2 = MAX_Z + 1;                   // one row minus one
    localparam int A1W    = $clog2(DEPTH1);
    localparam int A2W    = $clog2(DEPTH2);
    localparam int PRW    = $clog2(DEPTH1 + 1);
    localparam int BW     = FIFO_CNT_W + 1;
    localparam int MW     = 2 * SAMPLE_W;

    localparam int SY_RST   = (MAX_Y < SIZE_RST) ? MAX_Y : SIZE_RST;
    localparam int SZ_RST   = (MAX_Z < SIZE_RST) ? MAX_Z : SIZE_RST;
    localparam int PX_RST   = SIZE_RST + 2;
    localparam int PY_RST   = SY_RST + 2;
    localparam int PZ_RST   = SZ_RST + 2;
    localparam int L1M1_RST = (PY_RST - 1) * PZ_RST - 1;
    localparam int L2M1_RST = PZ_RST - 2;

    // configuration, kept as padded extents and segment lengths minus one
    logic [XW-1:0]        r_px, n_px;
    logic [YW-1:0]        r_py, n_py;
    logic [ZW-1:0]        r_pz, n_pz;
    logic [A1W-1:0]       r_l1m1, n_l1m1;
    logic [A2W-1:0]       r_l2m1, n_l2m1;
    logic [WEIGHT_W-1:0]  r_cw, n_cw, r_fw, n_fw;
    logic [PRW-1:0]       prod;
    logic                 size_wr;
    logic                 cfg_acc;

    // stream position and delay pointers
    logic [XW-1:0]        r_x;
    logic [YW-1:0]        r_y;
    logic [ZW-1:0]        r_z;
    logic [A1W-1:0]       r_ptr1;
    logic [A2W-1:0]       r_ptr2;
    logic                 acc;
    logic                 emit;
    logic                 last;

    // delay memories: plane segments {s|E} and row segments {A|D}
    logic [MW-1:0]        r_mem1 [DEPTH1];
    logic [MW-1:0]        r_mem2 [DEPTH2];
    logic [MW-1:0]        r_m1_q, r_m2_q;

    // stage 1: plane memory read returns
    logic                       r_v1, r_e1, r_last1;
    logic signed [SAMPLE_W-1:0] r_s1;
    logic [A1W-1:0]             r_wa1_1;
    // stage 2: row memory read returns, write-back
    logic                       r_v2, r_e2, r_last2;
    logic signed [SAMPLE_W-1:0] r_s2, r_a2, r_f2;
    logic [A1W-1:0]             r_wa1_2;
    logic [A2W-1:0]             r_wa2_2;
    // one-sample taps: centre and -z face
    logic signed [SAMPLE_W-1:0] r_b1, r_b2;

    t_operands            op;
    t_result              res, q_data;
    logic                 push;
    logic [1:0]           arith_pend;
    logic [FIFO_CNT_W-1:0] q_cnt;
    logic [BW-1:0]        busy;

    assign o_cfg_ready = 1'b1;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;
    assign acc         = i_valid && o_ready;

    // register writes; sizes are clamped to the supported range on the way in
    always_comb begin
        int sx;
        int sy;
        int sz;
        sx      = int'(i_cfg_data[XW-1:0]);
        sy      = int'(i_cfg_data[6:0]);
        sz      = int'(i_cfg_data[6:0]);
        n_px    = r_px;
        n_py    = r_py;
        n_pz    = r_pz;
        n_cw    = r_cw;
        n_fw    = r_fw;
        size_wr = 1'b0;
        if (cfg_acc) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_SIZE_X: begin
                    if (sx < 1) sx = 1;
                    else if (sx > SIZE_X_MAX) sx = SIZE_X_MAX;
                    n_px    = XW'(sx + 2);
                    size_wr = 1'b1;
                end
                CFG_SIZE_Y: begin
                    if (sy < 1) sy = 1;
                    else if (sy > MAX_Y) sy = MAX_Y;
                    n_py    = YW'(sy + 2);
                    size_wr = 1'b1;
                end
                CFG_SIZE_Z: begin
                    if (sz < 1) sz = 1;
                    else if (sz > MAX_Z) sz = MAX_Z;
                    n_pz    = ZW'(sz + 2);
                    size_wr = 1'b1;
                end
                CFG_CENTRE_W: n_cw = i_cfg_data[WEIGHT_W-1:0];
                CFG_FACE_W:   n_fw = i_cfg_data[WEIGHT_W-1:0];
                default: ;
            endcase
        end
        // plane segment: (py-1)*pz samples; row segment: pz-1 samples
        prod   = PRW'(n_py - 1'b1) * PRW'(n_pz);
        n_l1m1 = A1W'(prod - 1'b1);
        n_l2m1 = A2W'(n_pz - 2'd2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_px   <= XW'(PX_RST);
            r_py   <= YW'(PY_RST);
            r_pz   <= ZW'(PZ_RST);
            r_l1m1 <= A1W'(L1M1_RST);
            r_l2m1 <= A2W'(L2M1_RST);
            r_cw   <= CENTRE_W_RST;
            r_fw   <= FACE_W_RST;
        end else begin
            r_px   <= n_px;
            r_py   <= n_py;
            r_pz   <= n_pz;
            r_l1m1 <= n_l1m1;
            r_l2m1 <= n_l2m1;
            r_cw   <= n_cw;
            r_fw   <= n_fw;
        end
    end

    // interior test on the padded coordinates of the incoming sample
    assign emit = (r_x >= XW'(2)) && (r_y != '0) && (r_y != r_py - 1'b1)
               && (r_z != '0) && (r_z != r_pz - 1'b1);
    assign last = (r_x == r_px - 1'b1) && (r_y == r_py - 2'd2) && (r_z == r_pz - 2'd2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x    <= '0;
            r_y    <= '0;
            r_z    <= '0;
            r_ptr1 <= '0;
            r_ptr2 <= '0;
        end else if (size_wr) begin
            // frame restart
            r_x    <= '0;
            r_y    <= '0;
            r_z    <= '0;
            r_ptr1 <= '0;
            r_ptr2 <= '0;
        end else begin
            if (acc) begin
                r_ptr1 <= (r_ptr1 == r_l1m1) ? '0 : r_ptr1 + 1'b1;
                if (r_z == r_pz - 1'b1) begin
                    r_z <= '0;
                    if (r_y == r_py - 1'b1) begin
                        r_y <= '0;
                        r_x <= (r_x == r_px - 1'b1) ? '0 : r_x + 1'b1;
                    end else begin
                        r_y <= r_y + 1'b1;
                    end
                end else begin
                    r_z <= r_z + 1'b1;
                end
            end
            if (r_v1) begin
                r_ptr2 <= (r_ptr2 == r_l2m1) ? '0 : r_ptr2 + 1'b1;
            end
        end
    end

    // plane memory: read on accept, write back in stage 2
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_m1_q <= r_mem1[r_ptr1];
        end
        if (r_v2) begin
            r_mem1[r_wa1_2] <= {r_s2, r_m2_q[SAMPLE_W-1:0]};
        end
    end

    // row memory: read in stage 1, write back in stage 2
    always_ff @(posedge i_clk) begin
        if (r_v1) begin
            r_m2_q <= r_mem2[r_ptr2];
        end
        if (r_v2) begin
            r_mem2[r_wa2_2] <= {r_a2, r_b2};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= acc;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1    <= i_sample;
            r_e1    <= emit;
            r_last1 <= last;
            r_wa1_1 <= r_ptr1;
        end
        if (r_v1) begin
            r_s2    <= r_s1;
            r_a2    <= r_m1_q[MW-1:SAMPLE_W];
            r_f2    <= r_m1_q[SAMPLE_W-1:0];
            r_e2    <= r_e1;
            r_last2 <= r_last1;
            r_wa1_2 <= r_wa1_1;
            r_wa2_2 <= r_ptr2;
        end
        if (r_v2) begin
            r_b2 <= r_b1;
            r_b1 <= r_m2_q[MW-1:SAMPLE_W];
        end
    end

    always_comb begin
        op.valid = r_v2 && r_e2;
        op.last  = r_last2;
        op.s     = r_s2;
        op.f     = r_f2;
        op.e     = r_m2_q[SAMPLE_W-1:0];
        op.a     = r_a2;
        op.b     = r_m2_q[MW-1:SAMPLE_W];
        op.d     = r_b2;
        op.c     = r_b1;
    end

    sps3d_arith u_arith (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op       (op),
        .i_centre_w (r_cw),
        .i_face_w   (r_fw),
        .o_push     (push),
        .o_res      (res),
        .o_pending  (arith_pend)
    );

    sps3d_out_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (res),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (q_data),
        .o_count (q_cnt)
    );

    // credit: every result in flight has a queue slot reserved
    assign busy = BW'(q_cnt) + BW'(arith_pend) + BW'(r_v1 && r_e1) + BW'(r_v2 && r_e2);
    assign o_ready = (busy < BW'(FIFO_DEPTH));

    assign o_value   = q_data.value;
    assign o_last    = q_data.last;
    assign o_clipped = q_data.clipped;

endmodule

// File: src/sps3d_checker.sv
// Port-level assertions for the stencil core, bound to the top level.
`include "seven_point_stencil_3d_core_defines.svh"

module sps3d_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_ready,
    input logic               o_valid,
    input logic               i_ready,
    input logic signed [31:0] o_value,
    input logic               o_last,
    input logic               o_clipped
);

    logic r_seen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_seen <= 1'b1;
        end
    end

    `SPS3D_CHECK_RESET(a_reset_empty, i_clk, i_rst_n, !o_valid, "result valid after reset")

    `SPS3D_CHECK_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_value) && $stable(o_last) && $stable(o_clipped), "stalled result changed")

    `SPS3D_CHECK_NOW(a_clip_rail, i_clk, i_rst_n, o_valid && o_clipped, o_value == 32'sh7fffffff || o_value == 32'sh80000000, "clipped result not at a rail")

    `SPS3D_CHECK_NOW(a_no_phantom, i_clk, i_rst_n, o_valid, r_seen, "result without any sample")

endmodule

bind seven_point_stencil_3d_core sps3d_checker u_checker (.*);

// File: test/seven_point_stencil_3d_core_tb.sv
// Self-checking testbench for the streaming seven-point 3D stencil core.
`timescale 1ns / 100ps

module seven_point_stencil_3d_core_tb;
    import sps3d_pkg::*;

    // Geometry the core is built for; the predictor uses the same values.
    localparam int MAX_Y       = 64;
    localparam int MAX_Z       = 64;
    localparam int SIZE_YZ_W   = 7;
    localparam int PLANE_MAX   = (MAX_Y + 2) * (MAX_Z + 2);
    localparam int DELAY_DEPTH = 2 * PLANE_MAX + 1;

    localparam longint VALUE_MAX  = 2147483647;
    localparam longint VALUE_MIN  = -VALUE_MAX - 1;
    localparam longint ROUND_HALF = longint'(1) << (FRAC_BITS - 1);

    localparam logic [WEIGHT_W-1:0]  WEIGHT_MAX   = '1;
    localparam logic [WEIGHT_W-1:0]  WEIGHT_HALF  = 18'd131072;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED   = 3'd5;   // first index with no register

    localparam int CLK_HALF_NS   = 6;
    localparam int RESET_CYCLES  = 11;
    localparam int TAIL_CYCLES   = 12;      // pipeline depth plus a little margin
    localparam int HOLD_CYCLES   = 300;     // long receiver hold-off
    localparam int DRAIN_LIMIT   = 200000;
    localparam int X_PROBE_ITEMS = 90;      // ten planes of the 1x1 column grid
    localparam int RANDOM_ITEMS  = 650;
    localparam int TIMEOUT_NS    = 300_000_000;

    logic                       i_clk       = 1'b0;
    logic                       i_rst_n     = 1'b0;
    logic                       i_valid     = 1'b0;
    logic                       o_ready;
    logic signed [SAMPLE_W-1:0] i_sample    = '0;
    logic                       o_valid;
    logic                       i_ready     = 1'b0;
    logic signed [SAMPLE_W-1:0] o_value;
    logic                       o_last;
    logic                       o_clipped;
    logic                       i_cfg_valid = 1'b0;
    logic                       o_cfg_ready;
    logic [CFG_IDX_W-1:0]       i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]      i_cfg_data  = '0;

    seven_point_stencil_3d_core #(
        .MAX_Y (MAX_Y),
        .MAX_Z (MAX_Z)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_sample    (i_sample),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_value     (o_value),
        .o_last      (o_last),
        .o_clipped   (o_clipped),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // ------------------------------------------------------------------
    // Scoreboard: mirrors the delay line, raster position and registers,
    // and keeps the stencil results still owed by the core, oldest first.
    // ------------------------------------------------------------------
    class stencil_scoreboard;
        logic signed [SAMPLE_W-1:0] delay_line [DELAY_DEPTH];
        int unsigned                wr_ptr;
        int unsigned                pos_x, pos_y, pos_z;
        logic [SIZE_X_W-1:0]        size_x;
        logic [SIZE_YZ_W-1:0]       size_y, size_z;
        int unsigned                centre_w, face_w;
        t_result                    owed_results [$];
        int                         failures;

        function new();
            wr_ptr   = 0;
            size_x   = SIZE_X_W'(SIZE_RST);
            size_y   = SIZE_YZ_W'(SIZE_RST);
            size_z   = SIZE_YZ_W'(SIZE_RST);
            centre_w = 32'(CENTRE_W_RST);
            face_w   = 32'(FACE_W_RST);
            failures = 0;
            restart_frame();
        endfunction

        function void restart_frame();
            pos_x = 0;
            pos_y = 0;
            pos_z = 0;
        endfunction

        // Zero means one; anything above the build limit means the limit.
        function int unsigned clamp_extent(int unsigned v, int unsigned hi);
            if (v < 1) return 1;
            if (v > hi) return hi;
            return v;
        endfunction

        function int frame_len();
            return (clamp_extent(32'(size_x), SIZE_X_MAX) + 2)
                 * (clamp_extent(32'(size_y), MAX_Y) + 2)
                 * (clamp_extent(32'(size_z), MAX_Z) + 2);
        endfunction

        function int pending();
            return owed_results.size();
        endfunction

        function logic signed [SAMPLE_W-1:0] tap(int unsigned back);
            int unsigned idx;
            idx = wr_ptr + DELAY_DEPTH - back;
            if (idx >= DELAY_DEPTH) idx -= DELAY_DEPTH;
            return delay_line[idx];
        endfunction

        function void note_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_SIZE_X: begin
                    size_x = data[SIZE_X_W-1:0];
                    restart_frame();
                end
                CFG_SIZE_Y: begin
                    size_y = data[SIZE_YZ_W-1:0];
                    restart_frame();
                end
                CFG_SIZE_Z: begin
                    size_z = data[SIZE_YZ_W-1:0];
                    restart_frame();
                end
                CFG_CENTRE_W: centre_w = 32'(data[WEIGHT_W-1:0]);
                CFG_FACE_W:   face_w = 32'(data[WEIGHT_W-1:0]);
                default: ;
            endcase
        endfunction

        // One accepted sample: emit the result of the point behind it when
        // this sample is that point's +x face, then shift it into the line.
        function void note_sample(logic signed [SAMPLE_W-1:0] s);
            int unsigned sx, sy, sz, py, pz, plane;
            longint      faces, acc, r;
            t_result     res;
            sx    = clamp_extent(32'(size_x), SIZE_X_MAX);
            sy    = clamp_extent(32'(size_y), MAX_Y);
            sz    = clamp_extent(32'(size_z), MAX_Z);
            py    = sy + 2;
            pz    = sz + 2;
            plane = py * pz;
            if (pos_x >= 2 && pos_x <= sx + 1 && pos_y >= 1 && pos_y <= sy &&
                pos_z >= 1 && pos_z <= sz) begin
                faces = longint'(s) + longint'(tap(2 * plane))
                      + longint'(tap(plane + pz)) + longint'(tap(plane - pz))
                      + longint'(tap(plane + 1)) + longint'(tap(plane - 1));
                acc = faces * longint'(face_w) + longint'(tap(plane)) * longint'(centre_w);
                r = (acc + ROUND_HALF) >>> FRAC_BITS;   // floor shift: round half up
                res.clipped = 1'b0;
                if (r > VALUE_MAX) begin
                    r = VALUE_MAX;
                    res.clipped = 1'b1;
                end else if (r < VALUE_MIN) begin
                    r = VALUE_MIN;
                    res.clipped = 1'b1;
                end
                res.value = r[SAMPLE_W-1:0];
                res.last  = (pos_x == sx + 1 && pos_y == sy && pos_z == sz);
                owed_results.push_back(res);
            end
            delay_line[wr_ptr] = s;
            wr_ptr = (wr_ptr + 1 >= DELAY_DEPTH) ? 0 : wr_ptr + 1;
            pos_z++;
            if (pos_z >= pz) begin
                pos_z = 0;
                pos_y++;
                if (pos_y >= py) begin
                    pos_y = 0;
                    pos_x++;
                    if (pos_x >= sx + 2) pos_x = 0;
                end
            end
        endfunction

        function void check_result(logic signed [SAMPLE_W-1:0] value, logic last,
                                   logic clipped);
            t_result want;
            if (owed_results.size() == 0) begin
                $error("result request with nothing owed: value %0d last %0b clipped %0b",
                       value, last, clipped);
                failures++;
                return;
            end
            want = owed_results.pop_front();
            if (value !== want.value) begin
                $error("value: expected %0d, got %0d", want.value, value);
                failures++;
            end
            if (last !== want.last) begin
                $error("last: expected %0b, got %0b", want.last, last);
                failures++;
            end
            if (clipped !== want.clipped) begin
                $error("clipped: expected %0b, got %0b", want.clipped, clipped);
                failures++;
            end
        endfunction
    endclass

    stencil_scoreboard sb = new();

    // Clock
    always begin
        #(CLK_HALF_NS) i_clk = 1'b1;
        #(CLK_HALF_NS) i_clk = 1'b0;
    end

    // Hard stop in case a handshake never completes
    initial begin
        #(TIMEOUT_NS);
        $display("CHECKS FAILED");
        $finish;
    end

    // Idle lengths: mostly short, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 10);
        return $urandom_range(16, 48);
    endfunction

    // Sample values: extremes, small numbers around zero, and full-range noise
    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return 32'($urandom_range(0, 65535)) - 32'sd32768;
            3:       return 32'($urandom_range(0, 2)) - 32'sd1;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [WEIGHT_W-1:0] pick_weight();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return WEIGHT_MAX;
            2:       return CENTRE_W_RST;
            3:       return FACE_W_RST;
            default: return WEIGHT_W'($urandom());
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Result side: check every accepted request, then pick next ready.
    // A long hold-off is asked for by bumping hold_reqs from the stimulus.
    // ------------------------------------------------------------------
    int unsigned hold_reqs  = 0;
    int unsigned hold_seen  = 0;
    int unsigned hold_left  = 0;
    int unsigned stall_left = 0;
    bit          rx_calm    = 1'b0;
    bit          tx_calm    = 1'b0;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) sb.check_result(o_value, o_last, o_clipped);
        if ($urandom_range(0, 499) == 0) rx_calm = !rx_calm;
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else if (hold_seen != hold_reqs) begin
            hold_seen = hold_reqs;
            hold_left = HOLD_CYCLES - 1;
            i_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
            if (!rx_calm && $urandom_range(0, 99) < 25) stall_left = gap_len();
        end
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // One register write; valid drops for a cycle afterwards.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.note_write(idx, data);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // One sample request, after an optional random gap. Valid stays high
    // between back-to-back requests.
    task automatic send_sample(logic signed [SAMPLE_W-1:0] s);
        int gap;
        if ($urandom_range(0, 499) == 0) tx_calm = !tx_calm;
        gap = (tx_calm || $urandom_range(0, 99) < 65) ? 0 : gap_len();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_sample <= s;
        do @(posedge i_clk); while (!o_ready);
        sb.note_sample(s);
    endtask

    // Stop sending until every owed result is back, then let the pipeline
    // run dry so halo samples in flight are gone too.
    task automatic drain_results();
        int waited;
        i_valid <= 1'b0;
        waited = 0;
        while (sb.pending() > 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    task automatic stream_constant(logic signed [SAMPLE_W-1:0] v, int count);
        for (int i = 0; i < count; i++) send_sample(v);
    endtask

    // Random samples. hold_at: sample index where the receiver starts its
    // long hold-off. retune_at: index where the stream pauses, drains and a
    // weight is rewritten mid-frame (no restart).
    task automatic stream_frame(int count, int hold_at, int retune_at);
        for (int i = 0; i < count; i++) begin
            if (i == hold_at) hold_reqs <= hold_reqs + 1;
            if (i == retune_at) begin
                drain_results();
                write_reg($urandom_range(0, 1) ? CFG_FACE_W : CFG_CENTRE_W, pick_weight());
            end
            send_sample(pick_sample());
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        int  random_sent;
        int  flen;
        int  count;
        int  frames;
        bit  first_phase;
        bit  partial;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Smallest grid, weights left at reset: exactly one full frame
        write_reg(CFG_SIZE_X, 18'd1);
        write_reg(CFG_SIZE_Y, 18'd1);
        write_reg(CFG_SIZE_Z, 18'd1);
        stream_constant(32'sh7FFF_FFFF, 27);
        drain_results();

        // Full-scale weights on most negative samples: saturates low.
        // The frame is cut right after its only result.
        write_reg(CFG_CENTRE_W, WEIGHT_MAX);
        write_reg(CFG_FACE_W, WEIGHT_MAX);
        stream_constant(32'sh8000_0000, 23);
        drain_results();

        // Exact half LSB below zero must round up to zero; the size write
        // also restarts the cut frame.
        write_reg(CFG_SIZE_X, 18'd1);
        write_reg(CFG_CENTRE_W, WEIGHT_HALF);
        write_reg(CFG_FACE_W, '0);
        stream_constant(-32'sd1, 23);
        drain_results();

        // Tallest grid: size_y above the limit acts as the limit, size_x of
        // zero acts as one. The receiver holds off as the results start,
        // then a mid-frame weight change follows.
        write_reg(CFG_SIZE_X, 18'd0);
        write_reg(CFG_SIZE_Y, 18'd127);
        write_reg(CFG_SIZE_Z, 18'd2);
        write_reg(CFG_CENTRE_W, pick_weight());
        write_reg(CFG_FACE_W, pick_weight());
        flen = sb.frame_len();
        stream_frame(flen, 2 * flen / 3, 2 * flen / 3 + 100);
        drain_results();

        // size_x above its limit: start of the long x run
        write_reg(CFG_SIZE_X, 18'd2047);
        write_reg(CFG_SIZE_Y, 18'd1);
        write_reg(CFG_SIZE_Z, 18'd1);
        stream_frame(X_PROBE_ITEMS, -1, -1);
        drain_results();

        // Random phases: small grids, mostly whole frames back to back,
        // some cut short, weights and sizes changed between phases.
        random_sent = 0;
        first_phase = 1'b1;
        while (random_sent < RANDOM_ITEMS) begin
            if (first_phase || $urandom_range(0, 9) < 7)
                write_reg(CFG_SIZE_X, {7'($urandom()),
                          ($urandom_range(0, 9) == 0) ? 11'd0 : 11'($urandom_range(1, 4))});
            if (first_phase || $urandom_range(0, 9) < 7)
                write_reg(CFG_SIZE_Y, {11'($urandom()),
                          ($urandom_range(0, 5) == 0) ? 7'($urandom_range(6, 16))
                                                      : 7'($urandom_range(0, 5))});
            if (first_phase || $urandom_range(0, 9) < 7)
                write_reg(CFG_SIZE_Z, {11'($urandom()),
                          ($urandom_range(0, 5) == 0) ? 7'($urandom_range(6, 16))
                                                      : 7'($urandom_range(0, 5))});
            if ($urandom_range(0, 1)) write_reg(CFG_CENTRE_W, pick_weight());
            if ($urandom_range(0, 1)) write_reg(CFG_FACE_W, pick_weight());
            if ($urandom_range(0, 19) == 0)
                write_reg(CFG_IDX_W'(CFG_UNUSED + $urandom_range(0, 2)),
                          CFG_DATA_W'($urandom()));
            first_phase = 1'b0;

            flen   = sb.frame_len();
            frames = $urandom_range(1, 3);
            for (int f = 0; f < frames; f++) begin
                partial = ($urandom_range(0, 4) == 0);
                count   = partial ? $urandom_range(1, flen) : flen;
                stream_frame(count,
                             ($urandom_range(0, 19) == 0) ? $urandom_range(0, count - 1) : -1,
                             ($urandom_range(0, 7) == 0) ? $urandom_range(0, count - 1) : -1);
                random_sent += count;
                if (partial) break;
                // sender pause until everything owed is back
                if ($urandom_range(0, 9) == 0) drain_results();
            end
            drain_results();
        end

        drain_results();
        if (sb.pending() != 0) begin
            $error("%0d expected results never arrived", sb.pending());
            sb.failures++;
        end
        if (sb.failures == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: files.f
+incdir+src
src/sps3d_pkg.sv
src/sps3d_arith.sv
src/sps3d_out_fifo.sv
src/seven_point_stencil_3d_core.sv
src/sps3d_checker.sv
test/seven_point_stencil_3d_core_tb.sv
